FILE: rtl/hcml_pkg.sv
// Shared types, field widths and fixed tables of the hexahedral minmod limiter.
package hcml_pkg;

  localparam int NodeW     = 32;
  localparam int AvgW      = 32;
  localparam int CoordW    = 4;
  localparam int AlphaW    = 16;
  localparam int AlphaFrac = 14;
  localparam int SizeW     = 5;
  localparam int FaceW     = 32;
  localparam int DiffW     = 33;
  localparam int ScaleW    = 36;
  localparam int LimW      = 34;
  localparam int AccW      = 40;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgAlpha = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeX = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeY = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgSizeZ = 8'd3;

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqLimit = 1'b1;

  typedef logic signed [NodeW-1:0] node_t;
  typedef node_t [7:0] node_vec_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef acc_t [7:0] acc_vec_t;

  typedef struct packed {
    logic              req_type;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [CoordW-1:0] cell_z;
    node_t             node_in_0;
    node_t             node_in_1;
    node_t             node_in_2;
    node_t             node_in_3;
    node_t             node_in_4;
    node_t             node_in_5;
    node_t             node_in_6;
    node_t             node_in_7;
  } in_item_t;

  typedef struct packed {
    node_t node_out_0;
    node_t node_out_1;
    node_t node_out_2;
    node_t node_out_3;
    node_t node_out_4;
    node_t node_out_5;
    node_t node_out_6;
    node_t node_out_7;
  } out_item_t;

  // Nodes that make up each of the six faces.
  localparam logic [2:0] FaceNodes [6][4] = '{
    '{3'd0, 3'd3, 3'd4, 3'd7}, '{3'd1, 3'd2, 3'd5, 3'd6}, '{3'd0, 3'd1, 3'd4, 3'd5},
    '{3'd3, 3'd2, 3'd7, 3'd6}, '{3'd0, 3'd1, 3'd3, 3'd2}, '{3'd4, 3'd5, 3'd7, 3'd6}
  };

  // Rebuild matrix: bit j set means weight 2 on face j, clear means weight -1.
  localparam logic [5:0] RebuildTwo [8] = '{
    6'b010101, 6'b010110, 6'b011010, 6'b011001,
    6'b100101, 6'b100110, 6'b101010, 6'b101001
  };

endpackage

FILE: rtl/hcml_store.sv
// Node and cell-average memories, written by load beats and read one entry per cycle.
module hcml_store
  import hcml_pkg::*;
#(
  parameter int Cells = 4096,
  parameter int IdxW  = 12
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  node_vec_t       wr_nodes_i,
  input  logic            node_rd_en_i,
  input  logic [IdxW-1:0] node_rd_addr_i,
  output node_vec_t       node_rd_o,
  input  logic            avg_rd_en_i,
  input  logic [IdxW-1:0] avg_rd_addr_i,
  output node_t           avg_rd_o
);

  node_vec_t node_mem [Cells];
  node_t     avg_mem  [Cells];

  logic signed [NodeW+2:0] sum;
  node_t                   avg_wr;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + (NodeW+3)'(wr_nodes_i[i]);
    end
    // Floored division by eight; the mean of 32-bit values fits 32 bits.
    avg_wr = NodeW'(sum >>> 3);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      node_mem[wr_addr_i] <= wr_nodes_i;
      avg_mem[wr_addr_i]  <= avg_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_rd_en_i) begin
      node_rd_o <= node_mem[node_rd_addr_i];
    end
    if (avg_rd_en_i) begin
      avg_rd_o <= avg_mem[avg_rd_addr_i];
    end
  end

endmodule

FILE: rtl/hcml_div3.sv
// Two-stage divide by three with truncation toward zero and 32-bit saturation.
module hcml_div3
  import hcml_pkg::*;
(
  input  logic      clk_i,
  input  acc_vec_t  acc_i,
  output node_vec_t q_o
);

  localparam logic [AccW-1:0] SatPos  = AccW'(64'd3 * 64'd2147483648);
  localparam logic [AccW-1:0] SatNeg  = AccW'(64'd3 * 64'd2147483649);
  localparam logic [15:0]     Third16 = 16'd21845;
  localparam logic [17:0]     Recip18 = 18'd174763;

  logic [7:0]       neg_q, sat_q;
  logic [31:0]      p1_q [8];
  logic [17:0]      y_q  [8];

  // A magnitude below 2^33 splits as 2^16*hi + lo, and 2^16 = 3*21845 + 1,
  // so the quotient is 21845*hi + (hi + lo)/3 with a narrow remainder term.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      logic [AccW-1:0] mag;
      logic            neg;
      neg      = acc_i[i][AccW-1];
      mag      = neg ? AccW'(-acc_i[i]) : AccW'(acc_i[i]);
      neg_q[i] <= neg;
      sat_q[i] <= neg ? (mag >= SatNeg) : (mag >= SatPos);
      p1_q[i]  <= 32'(Third16) * 32'(mag[32:16]);
      y_q[i]   <= 18'(mag[32:16]) + 18'(mag[15:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      logic [35:0] prod;
      logic [32:0] q;
      prod = y_q[i] * Recip18;
      q    = 33'(p1_q[i]) + 33'(prod[35:19]);
      if (sat_q[i]) begin
        q_o[i] <= neg_q[i] ? node_t'(32'h8000_0000) : node_t'(32'h7fff_ffff);
      end else begin
        q_o[i] <= neg_q[i] ? NodeW'(-q) : NodeW'(q);
      end
    end
  end

endmodule

FILE: rtl/hex_cell_minmod_limiter.sv
// Top level of the hexahedral cell minmod slope limiter.
//
//  channel  direction  handshake               payload
//  in       in         in_valid_i/in_ready_o   in_data_i  (in_item_t)
//  out      out        out_valid_o/out_ready_i out_data_o (out_item_t)
//  cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A load beat writes the eight nodes and the cell average to memory as the
// beat is accepted. A request beat holds off further input until its
// result is offered, and the input is ready again in the same cycle, so a
// new request is not taken before the last one is through. The sequence
// is set by the single read port of the average memory (seven reads),
// the shared scaling multiplier (six differences), the limit and rebuild
// steps and the two divide-by-three stages. Reset clears the control state
// and sets the configuration registers to their defaults; the memories are
// not cleared. A stalled result waits in the output register and does not
// block a following load.
module hex_cell_minmod_limiter
  import hcml_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int Cells = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int IdxW  = $clog2(Cells);
  localparam int DimW  = $clog2(MAX_DIM);
  localparam logic [IdxW-1:0] Stride1 = IdxW'(1);
  localparam logic [IdxW-1:0] Stride2 = IdxW'(MAX_DIM);
  localparam logic [IdxW-1:0] Stride3 = IdxW'(MAX_DIM * MAX_DIM);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StDiff  = 3'd2;
  localparam logic [2:0] StLimit = 3'd3;
  localparam logic [2:0] StBuild = 3'd4;
  localparam logic [2:0] StDivA  = 3'd5;
  localparam logic [2:0] StDivB  = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  // Reduce a coordinate modulo the grid size by repeated subtraction.
  function automatic logic [DimW-1:0] dim_mod(input logic [CoordW-1:0] v);
    logic [CoordW:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= MAX_DIM) begin
        r = r - (CoordW+1)'(MAX_DIM);
      end
    end
    return DimW'(r);
  endfunction

  function automatic logic [7:0] eff_size(input logic [SizeW-1:0] s);
    if (s == '0) begin
      return 8'd1;
    end else if (int'(s) > MAX_DIM) begin
      return 8'(MAX_DIM);
    end
    return 8'(s);
  endfunction

  // Smallest magnitude with the common sign, or zero when the signs differ.
  function automatic logic signed [ScaleW-1:0] minmod(input logic signed [ScaleW-1:0] a,
                                                     input logic signed [ScaleW-1:0] b,
                                                     input logic signed [ScaleW-1:0] c);
    logic [ScaleW-1:0] ma, mb, mc, m;
    ma = a[ScaleW-1] ? ScaleW'(-a) : ScaleW'(a);
    mb = b[ScaleW-1] ? ScaleW'(-b) : ScaleW'(b);
    mc = c[ScaleW-1] ? ScaleW'(-c) : ScaleW'(c);
    m  = (mb < ma) ? mb : ma;
    m  = (mc < m) ? mc : m;
    if (a == '0 || b == '0 || c == '0 || a[ScaleW-1] != b[ScaleW-1] ||
        a[ScaleW-1] != c[ScaleW-1]) begin
      return '0;
    end
    return a[ScaleW-1] ? ScaleW'(-$signed(m)) : ScaleW'($signed(m));
  endfunction

  // Configuration registers.
  logic [AlphaW-1:0] alpha_q;
  logic [SizeW-1:0]  size_x_q, size_y_q, size_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= AlphaW'(16384);
      size_x_q <= SizeW'(16);
      size_y_q <= SizeW'(16);
      size_z_q <= SizeW'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAlpha: alpha_q  <= cfg_data_i;
        CfgSizeX: size_x_q <= cfg_data_i[SizeW-1:0];
        CfgSizeY: size_y_q <= cfg_data_i[SizeW-1:0];
        CfgSizeZ: size_z_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Input decode: cell index and boundary flags of the accepted beat.
  logic [DimW-1:0] px, py, pz;
  logic [IdxW-1:0] cell_k;
  logic [5:0]      bound_d;
  node_vec_t       in_nodes;
  logic            in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    px     = dim_mod(in_data_i.cell_x);
    py     = dim_mod(in_data_i.cell_y);
    pz     = dim_mod(in_data_i.cell_z);
    cell_k = IdxW'(32'(pz) * MAX_DIM * MAX_DIM + 32'(py) * MAX_DIM + 32'(px));
    // Even bits flag a usable lower neighbor, odd bits an upper one.
    bound_d[0] = px != '0;
    bound_d[1] = (8'(px) + 8'd1) < eff_size(size_x_q);
    bound_d[2] = py != '0;
    bound_d[3] = (8'(py) + 8'd1) < eff_size(size_y_q);
    bound_d[4] = pz != '0;
    bound_d[5] = (8'(pz) + 8'd1) < eff_size(size_z_q);
    in_nodes = {in_data_i.node_in_7, in_data_i.node_in_6, in_data_i.node_in_5,
                in_data_i.node_in_4, in_data_i.node_in_3, in_data_i.node_in_2,
                in_data_i.node_in_1, in_data_i.node_in_0};
  end

  // Sequencer state.
  logic [2:0]      state_q, state_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [IdxW-1:0] k_q;
  logic [5:0]      bound_q;

  // Datapath registers.
  node_t                    nb_q   [7];
  node_vec_t                node_q;
  logic signed [FaceW-1:0]  face_q [6];
  logic signed [ScaleW-1:0] sc_q   [6];
  logic signed [LimW-1:0]   lim_q  [6];
  acc_vec_t                 acc_q;

  logic            out_valid_q;
  out_item_t       out_q;

  // Memory read requests.
  logic            node_rd_en, avg_rd_en;
  logic [IdxW-1:0] avg_rd_addr;
  node_vec_t       node_rd;
  node_t           avg_rd;
  node_vec_t       div_q;

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Reads go out in the order: own cell, then lower and upper neighbor of
  // each axis in turn.
  always_comb begin
    node_rd_en  = state_q == StRead && cnt_q == 3'd0;
    avg_rd_en   = state_q == StRead && cnt_q != 3'd7;
    case (cnt_q)
      3'd1:    avg_rd_addr = k_q - Stride1;
      3'd2:    avg_rd_addr = k_q + Stride1;
      3'd3:    avg_rd_addr = k_q - Stride2;
      3'd4:    avg_rd_addr = k_q + Stride2;
      3'd5:    avg_rd_addr = k_q - Stride3;
      3'd6:    avg_rd_addr = k_q + Stride3;
      default: avg_rd_addr = k_q;
    endcase
  end

  hcml_store #(
    .Cells (Cells),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i          (clk_i),
    .wr_en_i        (in_acc && in_data_i.req_type == ReqLoad),
    .wr_addr_i      (cell_k),
    .wr_nodes_i     (in_nodes),
    .node_rd_en_i   (node_rd_en),
    .node_rd_addr_i (k_q),
    .node_rd_o      (node_rd),
    .avg_rd_en_i    (avg_rd_en),
    .avg_rd_addr_i  (avg_rd_addr),
    .avg_rd_o       (avg_rd)
  );

  hcml_div3 u_div3 (
    .clk_i (clk_i),
    .acc_i (acc_q),
    .q_o   (div_q)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.req_type == ReqLimit) begin
          state_d = StRead;
          cnt_d   = '0;
        end
      end
      StRead: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = StDiff;
          cnt_d   = '0;
        end
      end
      StDiff: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          state_d = StLimit;
        end
      end
      StLimit: state_d = StBuild;
      StBuild: state_d = StDivA;
      StDivA:  state_d = StDivB;
      StDivB:  state_d = StOut;
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == StOut && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath. Each state fills the registers that the next one reads.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      k_q     <= cell_k;
      bound_q <= bound_d;
    end

    // Read data arrives in the cycle after its address.
    if (state_q == StRead && cnt_q != 3'd0) begin
      nb_q[cnt_q - 3'd1] <= avg_rd;
    end
    if (state_q == StRead && cnt_q == 3'd1) begin
      node_q <= node_rd;
    end

    if (state_q == StDiff) begin
      logic signed [DiffW-1:0]          d;
      logic signed [DiffW+AlphaW:0]     prod;
      if (cnt_q[0]) begin
        d = DiffW'(nb_q[cnt_q + 3'd1]) - DiffW'(nb_q[0]);
      end else begin
        d = DiffW'(nb_q[0]) - DiffW'(nb_q[cnt_q + 3'd1]);
      end
      prod = $signed({1'b0, alpha_q}) * d;
      sc_q[cnt_q] <= bound_q[cnt_q] ? ScaleW'(prod >>> AlphaFrac) : '0;
    end

    // Face means are floored quarters of four node sums.
    if (state_q == StDiff && cnt_q == 3'd0) begin
      for (int j = 0; j < 6; j++) begin
        logic signed [FaceW+1:0] fs;
        fs = '0;
        for (int i = 0; i < 4; i++) begin
          fs = fs + (FaceW+2)'(node_q[FaceNodes[j][i]]);
        end
        face_q[j] <= FaceW'(fs >>> 2);
      end
    end

    // Lower faces are limited on avg - face, upper faces on face - avg.
    if (state_q == StLimit) begin
      for (int j = 0; j < 6; j++) begin
        logic signed [ScaleW-1:0] dev, m;
        if (j % 2 == 0) begin
          dev = ScaleW'(nb_q[0]) - ScaleW'(face_q[j]);
        end else begin
          dev = ScaleW'(face_q[j]) - ScaleW'(nb_q[0]);
        end
        m = minmod(dev, sc_q[(j / 2) * 2], sc_q[(j / 2) * 2 + 1]);
        if (j % 2 == 0) begin
          lim_q[j] <= LimW'(ScaleW'(nb_q[0]) - m);
        end else begin
          lim_q[j] <= LimW'(ScaleW'(nb_q[0]) + m);
        end
      end
    end

    if (state_q == StBuild) begin
      for (int i = 0; i < 8; i++) begin
        acc_t a;
        a = '0;
        for (int j = 0; j < 6; j++) begin
          if (RebuildTwo[i][j]) begin
            a = a + (AccW'(lim_q[j]) <<< 1);
          end else begin
            a = a - AccW'(lim_q[j]);
          end
        end
        acc_q[i] <= a;
      end
    end

    if (state_q == StOut && (!out_valid_q || out_ready_i)) begin
      out_q.node_out_0 <= div_q[0];
      out_q.node_out_1 <= div_q[1];
      out_q.node_out_2 <= div_q[2];
      out_q.node_out_3 <= div_q[3];
      out_q.node_out_4 <= div_q[4];
      out_q.node_out_5 <= div_q[5];
      out_q.node_out_6 <= div_q[6];
      out_q.node_out_7 <= div_q[7];
    end
  end

endmodule
